>>> src/jrrm_pkg.sv
// ----------------------------------------------------------------------------
// jrrm_pkg
// Shared widths, register map, reset values and types of the jump-reset
// running mean block.
// ----------------------------------------------------------------------------
package jrrm_pkg;

  localparam int POS_W     = 32;                 // position sample / mean width
  localparam int CNT_W     = 16;                 // sample count width
  localparam int WIN_W     = 20;                 // window register width
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int DIV_STEPS = WIN_W / 2;          // radix-4: two quotient bits a cycle
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_WINDOW_XY = 2'd0;
  localparam logic [1:0] REG_WINDOW_Z  = 2'd1;
  localparam logic [1:0] REG_CAP_XY    = 2'd2;
  localparam logic [1:0] REG_CAP_Z     = 2'd3;

  localparam logic [WIN_W-1:0] WINDOW_XY_RST = 20'd512;
  localparam logic [WIN_W-1:0] WINDOW_Z_RST  = 20'd3840;
  localparam logic [CNT_W-1:0] CAP_XY_RST    = 16'd1000;
  localparam logic [CNT_W-1:0] CAP_Z_RST     = 16'd2000;

  typedef struct packed {
    logic [WIN_W-1:0] window_xy;
    logic [WIN_W-1:0] window_z;
    logic [CNT_W-1:0] cap_xy;
    logic [CNT_W-1:0] cap_z;
  } cfg_t;

endpackage

>>> src/jrrm_regs.sv
// ----------------------------------------------------------------------------
// jrrm_regs
// APB-style configuration registers: windows and count caps.
// ----------------------------------------------------------------------------
module jrrm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jrrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [jrrm_pkg::DATA_W-1:0]   pwdata,
  output logic [jrrm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output jrrm_pkg::cfg_t                cfg_o
);
  import jrrm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_xy <= WINDOW_XY_RST;
      cfg_q.window_z  <= WINDOW_Z_RST;
      cfg_q.cap_xy    <= CAP_XY_RST;
      cfg_q.cap_z     <= CAP_Z_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_XY: cfg_q.window_xy <= pwdata[WIN_W-1:0];
        REG_WINDOW_Z:  cfg_q.window_z  <= pwdata[WIN_W-1:0];
        REG_CAP_XY:    cfg_q.cap_xy    <= pwdata[CNT_W-1:0];
        REG_CAP_Z:     cfg_q.cap_z     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_XY: prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_q.window_xy};
      REG_WINDOW_Z:  prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_q.window_z};
      REG_CAP_XY:    prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_q.cap_xy};
      REG_CAP_Z:     prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_q.cap_z};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/jrrm_div.sv
// ----------------------------------------------------------------------------
// jrrm_div
// Digit-serial restoring divider, two quotient bits per cycle, shared by
// the three axes. Dividend is a window-bounded magnitude, divisor a count.
// ----------------------------------------------------------------------------
module jrrm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [jrrm_pkg::WIN_W-1:0]   dividend_i,
  input  logic [jrrm_pkg::CNT_W-1:0]   divisor_i,
  output logic                         busy_o,
  output logic [jrrm_pkg::WIN_W-1:0]   quot_o
);
  import jrrm_pkg::*;

  logic              busy_q;
  logic [DCNT_W-1:0] step_q;
  logic [WIN_W-1:0]  num_q;
  logic [WIN_W-1:0]  quot_q;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  rem_mid;
  logic [CNT_W-1:0]  rem_d;
  logic [CNT_W:0]    t1;
  logic [CNT_W:0]    t2;
  logic              ge1;
  logic              ge2;

  // two chained restoring steps on a narrow remainder
  always_comb begin
    t1      = {rem_q, num_q[WIN_W-1]};
    ge1     = (t1 >= {1'b0, den_q});
    rem_mid = ge1 ? CNT_W'(t1 - {1'b0, den_q}) : t1[CNT_W-1:0];
    t2      = {rem_mid, num_q[WIN_W-2]};
    ge2     = (t2 >= {1'b0, den_q});
    rem_d   = ge2 ? CNT_W'(t2 - {1'b0, den_q}) : t2[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= DCNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[WIN_W-3:0], 2'b00};
      rem_q  <= rem_d;
      quot_q <= {quot_q[WIN_W-3:0], ge1, ge2};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> src/jump_reset_running_mean_top.sv
// ----------------------------------------------------------------------------
// jump_reset_running_mean_top
// Three-axis running mean with jump reset on out-of-window samples.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   sample_x_i, sample_y_i, sample_z_i
//   out      source     out_valid_o / out_stall_i mean_x_o, mean_y_o, mean_z_o
//   cfg      sink       psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// An item runs per axis through a difference and window check, a division
// in the shared serial divider (two quotient bits a cycle) and an update;
// an out-of-window axis jumps at its check and skips the division. Most of
// an item's time goes to the serial divider. One item is worked at a time.
// Reset clears means, counts and registers to their reset values.
// A stalled result waits in the output register; the next sample is taken
// meanwhile and holds at its end until the output register frees up.
// ----------------------------------------------------------------------------
module jump_reset_running_mean_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           sample_x_i,
  input  logic signed [31:0]           sample_y_i,
  input  logic signed [31:0]           sample_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           mean_x_o,
  output logic signed [31:0]           mean_y_o,
  output logic signed [31:0]           mean_z_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jrrm_pkg::ADDR_W-1:0]  paddr,
  input  logic [jrrm_pkg::DATA_W-1:0]  pwdata,
  output logic [jrrm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import jrrm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIFF = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  cfg_t              cfg;
  logic [1:0]        state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic [POS_W-1:0]  samp_q [NUM_AXES];
  logic [POS_W-1:0]  avg_q  [NUM_AXES];
  logic [CNT_W-1:0]  cnt_q  [NUM_AXES];
  logic [POS_W-1:0]  mean_q [NUM_AXES];
  logic              out_valid_q;
  logic [CNT_W-1:0]  inc_q, inc_d;
  logic              neg_q;

  logic              in_acc;
  logic [POS_W-1:0]  cur_samp;
  logic [POS_W-1:0]  cur_avg;
  logic [CNT_W-1:0]  cur_cnt;
  logic [WIN_W-1:0]  cur_win;
  logic [CNT_W-1:0]  cur_cap;
  logic [POS_W:0]    diff;
  logic [POS_W:0]    mag;
  logic              in_win;
  logic [POS_W-1:0]  quot_s;
  logic              div_start;
  logic              div_busy;
  logic [WIN_W-1:0]  quot;
  logic              avg_we;
  logic [POS_W-1:0]  avg_wd;
  logic [CNT_W-1:0]  cnt_wd;
  logic              out_load;

  jrrm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jrrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag[WIN_W-1:0]),
    .divisor_i  (inc_d),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cur_samp = samp_q[axis_q];
    cur_avg  = avg_q[axis_q];
    cur_cnt  = cnt_q[axis_q];
    cur_win  = (axis_q == AXIS_Z) ? cfg.window_z : cfg.window_xy;
    cur_cap  = (axis_q == AXIS_Z) ? cfg.cap_z : cfg.cap_xy;
    diff     = {cur_samp[POS_W-1], cur_samp} - {cur_avg[POS_W-1], cur_avg};
    mag      = diff[POS_W] ? (POS_W+1)'(-diff) : diff;
    // strictly inside the window; magnitude then fits the window width
    in_win   = (mag < {{(POS_W+1-WIN_W){1'b0}}, cur_win});
    inc_d    = (cur_cnt == CNT_MAX) ? cur_cnt : CNT_W'(cur_cnt + 1'b1);
    quot_s   = neg_q ? POS_W'(-{{(POS_W-WIN_W){1'b0}}, quot})
                     : {{(POS_W-WIN_W){1'b0}}, quot};
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    div_start = 1'b0;
    avg_we    = 1'b0;
    avg_wd    = cur_samp;
    cnt_wd    = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DIFF;
          axis_d  = AXIS_X;
        end
      end
      ST_DIFF: begin
        if (in_win) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          // jump: mean takes the sample, count restarts
          avg_we = 1'b1;
          if (axis_q == AXIS_Z) begin
            state_d = ST_FIN;
          end else begin
            axis_d  = AXIS_W'(axis_q + 1'b1);
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          avg_we = 1'b1;
          avg_wd = POS_W'(cur_avg + quot_s);
          cnt_wd = (inc_q > cur_cap) ? cur_cap : inc_q;
          if (axis_q == AXIS_Z) begin
            state_d = ST_FIN;
          end else begin
            axis_d  = AXIS_W'(axis_q + 1'b1);
            state_d = ST_DIFF;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        avg_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (avg_we) begin
        avg_q[axis_q] <= avg_wd;
        cnt_q[axis_q] <= cnt_wd;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q[0] <= sample_x_i;
      samp_q[1] <= sample_y_i;
      samp_q[2] <= sample_z_i;
    end
    if (div_start) begin
      inc_q <= inc_d;
      neg_q <= diff[POS_W];
    end
    if (out_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        mean_q[i] <= avg_q[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_x_o    = mean_q[0];
  assign mean_y_o    = mean_q[1];
  assign mean_z_o    = mean_q[2];

  // an accepted sample starts on the first axis
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DIFF) && (axis_q == AXIS_X))
    else $error("sample transfer did not start the first axis");

  // the divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide state");

  // results are released only after the last axis
  a_fin_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (axis_q == AXIS_Z))
    else $error("finish reached before the last axis");

  // a new result is loaded only when the output register frees up
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while a transfer waits");

endmodule

>>> verif/tb_jump_reset_running_mean_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jump_reset_running_mean_top
// Drives position samples through the three-axis running mean and checks
// every mean against a cycle-free predictor kept in the bench. Directed
// cases cover the sample extremes, zero and full windows, small and odd caps
// and register writes with bits above the register width. Random phases then
// re-program the registers and mostly send samples that land near the
// current mean, with far jumps mixed in. The sender idles in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_jump_reset_running_mean_top;

  import jrrm_pkg::*;

  localparam int IDLE_LIMIT   = 5000;  // cycles with no transfer before giving up
  localparam int ITEMS_PHASE  = 125;
  localparam int NUM_PHASES   = 8;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } mean_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [POS_W-1:0]  sample_x_i;
  logic signed [POS_W-1:0]  sample_y_i;
  logic signed [POS_W-1:0]  sample_z_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [POS_W-1:0]  mean_x_o;
  logic signed [POS_W-1:0]  mean_y_o;
  logic signed [POS_W-1:0]  mean_z_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // predictor state and register copies
  logic signed [POS_W-1:0]  mean_q  [NUM_AXES];
  logic [CNT_W-1:0]         count_q [NUM_AXES];
  logic [WIN_W-1:0]         win_xy_q;
  logic [WIN_W-1:0]         win_z_q;
  logic [CNT_W-1:0]         cap_xy_q;
  logic [CNT_W-1:0]         cap_z_q;

  mean_t pending_means [$];
  int    mismatches;
  int    burst_left;
  int    idle_cycles;
  int    stall_mode;
  int    stall_span;

  jump_reset_running_mean_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .sample_z_i  (sample_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_x_o    (mean_x_o),
    .mean_y_o    (mean_y_o),
    .mean_z_o    (mean_z_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one axis of the running mean: in-window samples pull the mean by diff / count,
  // anything else makes it jump and restarts the count
  function automatic void advance_axis(input int ax, input logic signed [POS_W-1:0] smp,
                                       input logic [WIN_W-1:0] win,
                                       input logic [CNT_W-1:0] cap);
    longint      diff;
    longint      mag;
    longint      moved;
    int unsigned c;
    diff = longint'(smp) - longint'(mean_q[ax]);
    mag  = (diff < 0) ? -diff : diff;
    if (mag < longint'(win)) begin
      c = 32'(count_q[ax]);
      if (count_q[ax] != CNT_MAX) c = c + 1;
      moved         = longint'(mean_q[ax]) + diff / longint'(c);
      mean_q[ax]    = moved[POS_W-1:0];
      count_q[ax]   = c[CNT_W-1:0];
    end else begin
      mean_q[ax]  = smp;
      count_q[ax] = '0;
    end
    if (count_q[ax] > cap) count_q[ax] = cap;
  endfunction

  // mostly near the current mean, sometimes anywhere in the range
  function automatic logic signed [POS_W-1:0] pick_coord(input int ax,
                                                         input logic [WIN_W-1:0] win);
    int span;
    int off;
    if ($urandom_range(0, 5) == 0) return $urandom;
    span = int'(win) + 2;
    off  = int'($urandom_range(0, 2 * span)) - span;
    return mean_q[ax] + off;
  endfunction

  task automatic send_sample(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z);
    int    gap;
    mean_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    sample_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    // transfer taken at this edge
    advance_axis(0, x, win_xy_q, cap_xy_q);
    advance_axis(1, y, win_xy_q, cap_xy_q);
    advance_axis(2, z, win_z_q, cap_z_q);
    want.x = mean_q[0];
    want.y = mean_q[1];
    want.z = mean_q[2];
    pending_means.push_back(want);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_means.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WINDOW_XY: win_xy_q = value[WIN_W-1:0];
      REG_WINDOW_Z:  win_z_q  = value[WIN_W-1:0];
      REG_CAP_XY:    cap_xy_q = value[CNT_W-1:0];
      REG_CAP_Z:     cap_z_q  = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_sample(32'sd0, 32'sd0, 32'sd0);
    send_sample(32'sd100, -32'sd100, 32'sd1000);
    send_sample(32'sd300, -32'sd350, 32'sd2000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, -32'sd1);
    send_sample(32'h7FFF_FE00, 32'h8000_01FF, -32'sd3839);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
  endtask

  task automatic test_window_zero();
    wait_drained();
    write_reg(REG_WINDOW_XY, 32'd0);
    write_reg(REG_WINDOW_Z, 32'd0);
    send_sample(32'sd0, 32'sd0, 32'sd0);
    send_sample(32'sd0, 32'sd0, 32'sd0);
    send_sample(32'sd1, -32'sd1, 32'sd5);
  endtask

  task automatic test_divisor_above_cap();
    wait_drained();
    write_reg(REG_WINDOW_XY, 32'h000F_FFFF);
    write_reg(REG_WINDOW_Z, 32'h000F_FFFF);
    write_reg(REG_CAP_XY, 32'd1);
    write_reg(REG_CAP_Z, 32'd2);
    send_sample(32'sd1000, -32'sd1000, 32'sd7000);
    send_sample(32'sd1777, -32'sd1333, 32'sd6001);
    send_sample(32'sd250, -32'sd2500, 32'sd9999);
    send_sample(-32'sd77, 32'sd11, 32'sd5555);
    send_sample(32'sd12345, -32'sd54321, 32'sd4000);
  endtask

  task automatic test_cap_extremes();
    wait_drained();
    // bit 16 is dropped, so the x/y cap becomes zero
    write_reg(REG_CAP_XY, 32'h0001_0000);
    write_reg(REG_CAP_Z, 32'h0000_FFFF);
    send_sample(32'sd500, 32'sd600, 32'sd700);
    send_sample(32'sd900, 32'sd100, 32'sd900);
    send_sample(32'sd800, 32'sd300, 32'sd1100);
    send_sample(32'sd700, 32'sd200, 32'sd1300);
  endtask

  task automatic test_register_width();
    wait_drained();
    write_reg(REG_WINDOW_XY, 32'hFFF0_0100);
    write_reg(REG_WINDOW_Z, 32'hABC0_0000);
    send_sample(32'sd700, 32'sd200, 32'sd1300);
    send_sample(32'sd955, 32'sd456, 32'sd1300);
    send_sample(32'sd956, 32'sd199, -32'sd1300);
  endtask

  task automatic test_random();
    logic [WIN_W-1:0] wxy;
    logic [WIN_W-1:0] wz;
    logic [CNT_W-1:0] cxy;
    logic [CNT_W-1:0] cz;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 2))
        0:       wxy = WIN_W'($urandom_range(1, 64));
        1:       wxy = WIN_W'($urandom_range(256, 8192));
        default: wxy = WIN_W'($urandom_range(0, 20'hF_FFFF));
      endcase
      wz  = (ph == 1) ? 20'hF_FFFF : wxy ^ WIN_W'($urandom_range(0, 4095));
      cxy = (ph == 2) ? CNT_W'(1) : CNT_W'($urandom_range(1, 8));
      cz  = (ph == 1) ? CNT_W'(65534) : CNT_W'($urandom_range(9, 2000));
      if (ph == 1) wxy = 20'hF_FFFF;
      if (ph == 3) begin
        cxy = CNT_W'(65534);
        cz  = CNT_W'(1);
      end
      write_reg(REG_WINDOW_XY, {$urandom} & ~32'hF_FFFF | 32'(wxy));
      write_reg(REG_WINDOW_Z, 32'(wz));
      write_reg(REG_CAP_XY, 32'(cxy));
      write_reg(REG_CAP_Z, {$urandom} & ~32'hFFFF | 32'(cz));
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        send_sample(pick_coord(0, win_xy_q), pick_coord(1, win_xy_q),
                    pick_coord(2, win_z_q));
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_x_i  = '0;
    sample_y_i  = '0;
    sample_z_i  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    burst_left  = 0;
    win_xy_q    = WINDOW_XY_RST;
    win_z_q     = WINDOW_Z_RST;
    cap_xy_q    = CAP_XY_RST;
    cap_z_q     = CAP_Z_RST;
    for (int a = 0; a < NUM_AXES; a++) begin
      mean_q[a]  = '0;
      count_q[a] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_window_zero();
    test_divisor_above_cap();
    test_cap_extremes();
    test_register_width();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_jump_reset_running_mean_top: clean");
    end else begin
      $display("tb_jump_reset_running_mean_top: errors");
    end
    $finish;
  end

  // receiver stall pattern: free-running, sparse random, or mostly stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_span  <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(20, 300);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 2) == 0);
        default: out_stall_i <= ($urandom_range(0, 59) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_means
    mean_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result x %0d y %0d z %0d", $time,
                 mean_x_o, mean_y_o, mean_z_o);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (mean_x_o !== want.x) begin
          $display("%0t: mean_x expected %0d actual %0d", $time, want.x, mean_x_o);
          mismatches++;
        end
        if (mean_y_o !== want.y) begin
          $display("%0t: mean_y expected %0d actual %0d", $time, want.y, mean_y_o);
          mismatches++;
        end
        if (mean_z_o !== want.z) begin
          $display("%0t: mean_z expected %0d actual %0d", $time, want.z, mean_z_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_jump_reset_running_mean_top: errors");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
src/jrrm_pkg.sv
src/jrrm_regs.sv
src/jrrm_div.sv
src/jump_reset_running_mean_top.sv
verif/tb_jump_reset_running_mean_top.sv
